@@ hdl/assert_macros.svh @@
// assertion macros used by the controller
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

@@ hdl/m4xf_pkg.sv @@
// package: types, codes and arithmetic helpers of the matrix unit
`default_nettype none
package m4xf_pkg;
  localparam int ElemW = 32;
  localparam int NumElem = 16;
  localparam int FracBits = 16;

  typedef enum logic [2:0] {
    CMD_WR_CUR  = 3'd0,
    CMD_WR_SEC  = 3'd1,
    CMD_READ    = 3'd2,
    CMD_ADD     = 3'd3,
    CMD_SUB     = 3'd4,
    CMD_COMPOSE = 3'd5,
    CMD_SCALE   = 3'd6,
    CMD_XFORM   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ELEM,
    ST_XFORM,
    ST_COPY,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_SCALE,
    OP_COMPOSE
  } elem_op_t;

  // controller to datapath
  typedef struct packed {
    logic       load;      // capture the transaction
    logic       wr_cur;
    logic       wr_sec;
    logic       elem_step; // update one element of current (or tmp)
    elem_op_t   op;
    logic [3:0] idx;
    logic       copy_step; // move tmp element back into current
    logic       xform;     // compute transformed vector
    logic       load_read; // capture readback
    logic       out_set;
    logic       out_clr;
  } dp_cmd_t;

  typedef struct packed {
    logic out_valid;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -36'sh0_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // floor-shifted q16.16 product, 48 significant bits
  function automatic logic signed [47:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    return p[63:16];
  endfunction
endpackage
`default_nettype wire

@@ hdl/m4xf_datapath.sv @@
// datapath: matrix registers, multipliers, adders and result register
`default_nettype none
module m4xf_datapath (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire m4xf_pkg::dp_cmd_t  cmd,
  output m4xf_pkg::dp_stat_t      stat,
  input  wire logic [3:0]         in_idx,
  input  wire logic signed [31:0] in_value,
  input  wire logic [127:0]       in_vec,
  input  wire logic               out_take,
  output logic [191:0]            out_data
);
  logic signed [31:0] cur_r [16];
  logic signed [31:0] sec_r [16];
  logic signed [31:0] tmp_r [16];
  logic signed [31:0] val_r;
  logic [3:0]         idx_r;
  logic signed [31:0] vec_r [4];
  logic [191:0]       res_r;
  logic               res_vld_r;
  logic signed [31:0] elem_nxt;
  logic signed [49:0] acc;
  logic [1:0]         row, col;
  logic signed [31:0] xo [4];

  assign row = cmd.idx[3:2];
  assign col = cmd.idx[1:0];

  // one element per cycle: four multipliers for compose, one for scale
  always_comb begin
    acc = '0;
    elem_nxt = '0;
    unique case (cmd.op)
      m4xf_pkg::OP_ADD:
        elem_nxt = m4xf_pkg::sat32(36'(cur_r[cmd.idx]) + 36'(sec_r[cmd.idx]));
      m4xf_pkg::OP_SUB:
        elem_nxt = m4xf_pkg::sat32(36'(cur_r[cmd.idx]) - 36'(sec_r[cmd.idx]));
      m4xf_pkg::OP_SCALE: begin
        acc = 50'(m4xf_pkg::qmul(cur_r[cmd.idx], val_r));
        elem_nxt = (acc > 50'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                   (acc < -50'sh8000_0000) ? -32'sh8000_0000 : acc[31:0];
      end
      default: begin
        for (int k = 0; k < 4; k++)
          acc = acc + 50'(m4xf_pkg::qmul(cur_r[{row, 2'(k)}], sec_r[{2'(k), col}]));
        elem_nxt = (acc > 50'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
                   (acc < -50'sh8000_0000) ? -32'sh8000_0000 : acc[31:0];
      end
    endcase
  end

  // vector transform: sixteen multipliers, four per row sum
  always_comb begin
    logic signed [49:0] s;
    for (int i = 0; i < 4; i++) begin
      s = '0;
      for (int k = 0; k < 4; k++)
        s = s + 50'(m4xf_pkg::qmul(cur_r[4 * i + k], vec_r[k]));
      xo[i] = (s > 50'sh7FFF_FFFF) ? 32'sh7FFF_FFFF :
              (s < -50'sh8000_0000) ? -32'sh8000_0000 : s[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) cur_r[i] <= '0;
    end else if (cmd.wr_cur) begin
      cur_r[idx_r] <= val_r;
    end else if (cmd.elem_step) begin
      if (cmd.op == m4xf_pkg::OP_COMPOSE) tmp_r[cmd.idx] <= elem_nxt;
      else cur_r[cmd.idx] <= elem_nxt;
    end else if (cmd.copy_step) begin
      for (int i = 0; i < 16; i++) cur_r[i] <= tmp_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_sec) sec_r[idx_r] <= val_r;
    if (cmd.load) begin
      idx_r <= in_idx;
      val_r <= in_value;
      for (int k = 0; k < 4; k++) vec_r[k] <= in_vec[32 * k +: 32];
    end
    if (cmd.xform) res_r <= {32'd0, xo[3], xo[2], xo[1], xo[0], 32'd0};
    else if (cmd.load_read) res_r <= {cur_r[idx_r], 128'd0, 32'd1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_vld_r <= 1'b0;
    else if (cmd.out_set) res_vld_r <= 1'b1;
    else if (cmd.out_clr && out_take) res_vld_r <= 1'b0;
  end

  assign stat.out_valid = res_vld_r;
  assign out_data = res_r;
endmodule
`default_nettype wire

@@ hdl/m4xf_ctrl.sv @@
// controller: sequences element passes and result hand-off
`default_nettype none
`include "assert_macros.svh"
module m4xf_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_fire,
  input  wire logic [2:0]         in_cmd,
  output logic                    in_ready,
  input  wire logic               out_ready,
  input  wire m4xf_pkg::dp_stat_t stat,
  output m4xf_pkg::dp_cmd_t       cmd
);
  m4xf_pkg::state_t state_r, state_nxt;
  m4xf_pkg::cmd_t   op_r, op_nxt;
  logic [3:0]       cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= m4xf_pkg::ST_IDLE;
      op_r    <= m4xf_pkg::CMD_WR_CUR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cnt_nxt = cnt_r;
    cmd = '0;
    cmd.idx = cnt_r;
    unique case (op_r)
      m4xf_pkg::CMD_ADD:   cmd.op = m4xf_pkg::OP_ADD;
      m4xf_pkg::CMD_SUB:   cmd.op = m4xf_pkg::OP_SUB;
      m4xf_pkg::CMD_SCALE: cmd.op = m4xf_pkg::OP_SCALE;
      default:             cmd.op = m4xf_pkg::OP_COMPOSE;
    endcase
    in_ready = 1'b0;
    unique case (state_r)
      m4xf_pkg::ST_IDLE: begin
        in_ready = !stat.out_valid;
        cmd.load = in_fire;
        if (in_fire) begin
          op_nxt = m4xf_pkg::cmd_t'(in_cmd);
          cnt_nxt = '0;
          state_nxt = (m4xf_pkg::cmd_t'(in_cmd) == m4xf_pkg::CMD_XFORM)
                      ? m4xf_pkg::ST_XFORM : m4xf_pkg::ST_ELEM;
        end
      end
      m4xf_pkg::ST_ELEM: begin
        unique case (op_r)
          m4xf_pkg::CMD_WR_CUR: begin
            cmd.wr_cur = 1'b1;
            state_nxt = m4xf_pkg::ST_IDLE;
          end
          m4xf_pkg::CMD_WR_SEC: begin
            cmd.wr_sec = 1'b1;
            state_nxt = m4xf_pkg::ST_IDLE;
          end
          m4xf_pkg::CMD_READ: begin
            cmd.load_read = 1'b1;
            cmd.out_set = 1'b1;
            state_nxt = m4xf_pkg::ST_OUT;
          end
          default: begin
            cmd.elem_step = 1'b1;
            cnt_nxt = cnt_r + 4'd1;
            if (cnt_r == 4'd15)
              state_nxt = (op_r == m4xf_pkg::CMD_COMPOSE)
                          ? m4xf_pkg::ST_COPY : m4xf_pkg::ST_IDLE;
          end
        endcase
      end
      m4xf_pkg::ST_COPY: begin
        cmd.copy_step = 1'b1;
        state_nxt = m4xf_pkg::ST_IDLE;
      end
      m4xf_pkg::ST_XFORM: begin
        cmd.xform = 1'b1;
        cmd.out_set = 1'b1;
        state_nxt = m4xf_pkg::ST_OUT;
      end
      m4xf_pkg::ST_OUT: begin
        cmd.out_clr = 1'b1;
        if (out_ready) state_nxt = m4xf_pkg::ST_IDLE;
      end
      default: state_nxt = m4xf_pkg::ST_IDLE;
    endcase
  end

  `CHK_IMPL(a_ready_idle, clk, rst_n, in_ready, state_r == m4xf_pkg::ST_IDLE)
  `CHK_NEXT(a_out_valid, clk, rst_n, cmd.out_set, stat.out_valid)
  `CHK_IMPL(a_wait_valid, clk, rst_n, state_r == m4xf_pkg::ST_OUT, stat.out_valid)
endmodule
`default_nettype wire

@@ hdl/matrix4_compose_and_transform_unit.sv @@
// top level of the 4x4 q16.16 matrix compose and transform unit
// usage:
//   input stream (in_*): one command per transaction; tdata carries cmd,
//   elem_index, value, vec_x..vec_w. result stream (out_*): read and
//   transform commands give one transaction; tuser is result_kind, tdata
//   carries out_x..out_w and elem_value.
// timing:
//   write: a load step, then a write step. read and transform: out_tvalid
//   is registered from the ST_ELEM or ST_XFORM state that follows the input
//   transaction, and the next command is taken in the cycle after the
//   result transaction. add, sub, scale: one element per cycle through
//   the element unit. compose: one element per cycle with four multipliers,
//   then a copy step back. transform uses sixteen multipliers at once.
// reset: rst_n low clears the current matrix, the controller and the
//   result valid flag; the second matrix is undefined until written.
// stall: a result waits in the output register until out_tready; no
//   new command is taken until it is delivered.
`default_nettype none
module matrix4_compose_and_transform_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // cmd[2:0], elem_index[6:3], value[38:7], vec_x, vec_y, vec_z, vec_w, pad
  input  wire logic [167:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_x[31:0], out_y, out_z, out_w, elem_value[159:128]
  output logic [159:0]      out_tdata,
  // result_kind
  output logic              out_tuser
);
  m4xf_pkg::dp_cmd_t  cmd;
  m4xf_pkg::dp_stat_t stat;
  logic [191:0]       res;
  logic               in_fire;

  assign in_fire = in_tvalid && in_tready;

  m4xf_ctrl u_ctrl (
    .clk, .rst_n, .in_fire,
    .in_cmd(in_tdata[2:0]), .in_ready(in_tready),
    .out_ready(out_tready), .stat, .cmd
  );

  m4xf_datapath u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_idx(in_tdata[6:3]), .in_value(in_tdata[38:7]),
    .in_vec(in_tdata[166:39]), .out_take(out_tready), .out_data(res)
  );

  assign out_tvalid = stat.out_valid;
  assign out_tuser  = res[0];
  assign out_tdata  = res[191:32];
endmodule
`default_nettype wire
